[hdl/crps_pkg.sv]
package crps_pkg;

    localparam int MaxSamples = 32;

    localparam int NWidth   = 6;
    localparam int TauWidth = 16;

    localparam logic [NWidth-1:0]   NReset   = 6'd10;
    localparam logic [TauWidth-1:0] TauReset = 16'd32768;

    // configuration register indexes
    localparam logic CfgSamples = 1'b0;
    localparam logic CfgTension = 1'b1;

    // micro-op codes of one sample
    localparam logic [4:0] OpT2   = 5'd0;
    localparam logic [4:0] OpT3   = 5'd1;
    localparam logic [4:0] OpPa   = 5'd2;
    localparam logic [4:0] OpPb   = 5'd3;
    localparam logic [4:0] OpPos  = 5'd4;
    localparam logic [4:0] OpAttr = 5'd16;
    localparam logic [4:0] OpLast = 5'd23;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] field_of_view;
        logic signed [31:0] aspect_ratio;
        logic signed [31:0] near_clip;
        logic signed [31:0] far_clip;
        logic               path_end;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_fov;
        logic signed [31:0] out_aspect;
        logic signed [31:0] out_near;
        logic signed [31:0] out_far;
        logic               run_last;
        logic               path_done;
    } t_out_word;

    // x, y, z, fov, aspect, near, far
    typedef logic [6:0][31:0] t_point;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_CONS,
        S_EMIT,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic              load_pt;
        logic              init_window;
        logic              div_init;
        logic              div_step;
        logic              seg_init;
        logic              seg_sel;
        logic              mul;
        logic              cons;
        logic [4:0]        op;
        logic              t_adv;
        logic              emit;
        logic              run_last;
        logic              path_done;
        logic              shift;
        logic [NWidth-1:0] n;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    // signed divide by 2^16, rounding toward zero
    function automatic logic signed [55:0] trunc16(input logic signed [55:0] x);
        logic signed [55:0] adj;
        adj = x[55] ? (x + 56'sd65535) : x;
        return adj >>> 16;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [55:0] x);
        logic [31:0] r;
        if (x > 56'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (x < -56'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/crps_ctrl.sv]
module crps_ctrl #(
    parameter int MAX_SAMPLES = crps_pkg::MaxSamples
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_path_end,
    input  logic [crps_pkg::NWidth-1:0]   i_n,
    input  crps_pkg::t_stat               i_stat,
    output logic                          o_ready,
    output crps_pkg::t_cmd                o_cmd
);
    import crps_pkg::*;

    localparam int JW = $clog2(MAX_SAMPLES + 1);

    t_state            r_state, n_state;
    logic [1:0]        r_ps, n_ps;
    logic              r_last, n_last;
    logic              r_seg0, n_seg0;
    logic              r_seg1, n_seg1;
    logic              r_seg, n_seg;
    logic [JW-1:0]     r_j, n_j;
    logic [4:0]        r_op, n_op;
    logic [4:0]        r_cnt, n_cnt;
    logic [NWidth-1:0] r_n, n_n;
    logic [NWidth-1:0] n_clamp;
    logic              seg_end;
    logic              final_smp;

    always_comb begin
        if (i_n == '0) begin
            n_clamp = NWidth'(1);
        end else if (32'(i_n) > MAX_SAMPLES) begin
            n_clamp = NWidth'(MAX_SAMPLES);
        end else begin
            n_clamp = i_n;
        end
    end

    assign seg_end   = (r_j == JW'(r_n - NWidth'(1)));
    assign final_smp = seg_end && (r_seg || !r_seg1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ps    <= '0;
            r_last  <= 1'b0;
            r_seg0  <= 1'b0;
            r_seg1  <= 1'b0;
            r_seg   <= 1'b0;
            r_j     <= '0;
            r_op    <= '0;
            r_cnt   <= '0;
            r_n     <= NWidth'(1);
        end else begin
            r_state <= n_state;
            r_ps    <= n_ps;
            r_last  <= n_last;
            r_seg0  <= n_seg0;
            r_seg1  <= n_seg1;
            r_seg   <= n_seg;
            r_j     <= n_j;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ps    = r_ps;
        n_last  = r_last;
        n_seg0  = r_seg0;
        n_seg1  = r_seg1;
        n_seg   = r_seg;
        n_j     = r_j;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_n     = r_n;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.n       = r_n;
        o_cmd.op      = r_op;
        o_cmd.seg_sel = r_seg;

        unique case (r_state)
            S_IDLE: begin
                o_ready  = 1'b1;
                o_cmd.n  = n_clamp;
                if (i_valid) begin
                    o_cmd.load_pt     = 1'b1;
                    o_cmd.init_window = (r_ps == 2'd0);
                    o_cmd.div_init    = 1'b1;
                    n_last = i_path_end;
                    n_seg0 = (r_ps >= 2'd2);
                    n_seg1 = i_path_end && (r_ps != 2'd0);
                    n_n    = n_clamp;
                    n_cnt  = '0;
                    if ((r_ps >= 2'd2) || (i_path_end && (r_ps != 2'd0))) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    o_cmd.seg_init = 1'b1;
                    n_seg   = !r_seg0;
                    n_j     = '0;
                    n_op    = OpT2;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CONS;
            end
            S_CONS: begin
                o_cmd.cons = 1'b1;
                if (r_op == OpLast) begin
                    n_state = S_EMIT;
                end else begin
                    n_op    = r_op + 5'd1;
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.t_adv     = 1'b1;
                    o_cmd.run_last  = final_smp;
                    o_cmd.path_done = final_smp && r_last;
                    n_op = OpT2;
                    if (final_smp) begin
                        n_state = S_SHIFT;
                    end else if (seg_end) begin
                        o_cmd.seg_init = 1'b1;
                        o_cmd.seg_sel  = 1'b1;
                        n_seg   = 1'b1;
                        n_j     = '0;
                        n_state = S_MUL;
                    end else begin
                        n_j     = r_j + JW'(1);
                        n_state = S_MUL;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (r_last) begin
                    n_ps = 2'd0;
                end else if (r_ps != 2'd3) begin
                    n_ps = r_ps + 2'd1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/crps_dpath.sv]
module crps_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crps_pkg::t_cmd                i_cmd,
    input  crps_pkg::t_in_word            i_in,
    input  logic [crps_pkg::TauWidth-1:0] i_tau,
    input  logic                          i_ready,
    output crps_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output crps_pkg::t_out_word           o_out
);
    import crps_pkg::*;

    t_point             r_p, r_w0, r_w1, r_w2;
    t_point             r_val;
    t_point             pt_a, pt_b, pt_c, pt_d;
    t_point             pt_sel;
    logic [16:0]        r_dvd;
    logic [16:0]        r_q;
    logic [6:0]         r_rem;
    logic [6:0]         rs;
    logic [16:0]        r_t;
    logic [6:0]         r_r;
    logic [6:0]         rsum;
    logic [15:0]        r_t2, r_t3;
    logic signed [35:0] r_pa;
    logic signed [19:0] r_wt [4];
    logic signed [55:0] r_acc;
    logic signed [52:0] r_prod;
    logic signed [19:0] mul_a;
    logic signed [32:0] mul_b;
    logic [3:0]         kp;
    logic [2:0]         ka;
    logic [2:0]         attr;
    logic signed [19:0] st, st2, st3, s_a, s_b, c1;
    logic signed [55:0] pa, pb, prod, wsum;
    logic signed [55:0] wa, wb, wc, wd;
    logic               r_out_valid;
    t_out_word          r_out;

    assign kp   = 4'(i_cmd.op - OpPos);
    assign ka   = 3'(i_cmd.op - OpAttr);
    assign attr = 3'(ka[2:1]) + 3'd3;

    assign st  = $signed(20'(r_t));
    assign st2 = $signed(20'(r_t2));
    assign st3 = $signed(20'(r_t3));
    assign s_a = (st2 <<< 1) - st - st3;
    assign s_b = st2 - st3;
    assign c1  = (st3 <<< 1) - st2 - (st2 <<< 1);

    always_comb begin
        if (!i_cmd.seg_sel) begin
            pt_a = r_w0; pt_b = r_w1; pt_c = r_w2; pt_d = r_p;
        end else begin
            pt_a = r_w1; pt_b = r_w2; pt_c = r_p;  pt_d = r_p;
        end
        case (kp[1:0])
            2'd0:    pt_sel = pt_a;
            2'd1:    pt_sel = pt_b;
            2'd2:    pt_sel = pt_c;
            default: pt_sel = pt_d;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.op == OpT2) begin
            mul_a = st;
            mul_b = $signed(33'(r_t));
        end else if (i_cmd.op == OpT3) begin
            mul_a = st2;
            mul_b = $signed(33'(r_t));
        end else if (i_cmd.op == OpPa) begin
            mul_a = s_a;
            mul_b = $signed(33'(i_tau));
        end else if (i_cmd.op == OpPb) begin
            mul_a = s_b;
            mul_b = $signed(33'(i_tau));
        end else if (i_cmd.op < OpAttr) begin
            mul_a = r_wt[kp[1:0]];
            mul_b = $signed({pt_sel[kp[3:2]][31], pt_sel[kp[3:2]]});
        end else if (!ka[0]) begin
            mul_a = 20'sd65536 - st;
            mul_b = $signed({pt_b[attr][31], pt_b[attr]});
        end else begin
            mul_a = st;
            mul_b = $signed({pt_c[attr][31], pt_c[attr]});
        end
    end

    assign prod = 56'(r_prod);
    assign pa   = 56'(r_pa);
    assign pb   = prod;
    assign wa   = trunc16(pa);
    assign wd   = trunc16(-pb);
    assign wb   = trunc16((56'sd1 <<< 32) + pb + (56'(c1) <<< 16));
    assign wc   = trunc16(-pa - (56'(c1) <<< 16));
    assign wsum = r_acc + prod;

    assign rs   = {r_rem[5:0], r_dvd[16]};
    assign rsum = r_r + r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_p <= {i_in.far_clip, i_in.near_clip, i_in.aspect_ratio, i_in.field_of_view,
                    i_in.pos_z, i_in.pos_y, i_in.pos_x};
        end
        if (i_cmd.init_window) begin
            r_w0 <= {i_in.far_clip, i_in.near_clip, i_in.aspect_ratio, i_in.field_of_view,
                     i_in.pos_z, i_in.pos_y, i_in.pos_x};
            r_w1 <= {i_in.far_clip, i_in.near_clip, i_in.aspect_ratio, i_in.field_of_view,
                     i_in.pos_z, i_in.pos_y, i_in.pos_x};
            r_w2 <= {i_in.far_clip, i_in.near_clip, i_in.aspect_ratio, i_in.field_of_view,
                     i_in.pos_z, i_in.pos_y, i_in.pos_x};
        end else if (i_cmd.shift) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
            r_w2 <= r_p;
        end

        // restoring divide of 2^16 by N: step quotient q0 and remainder r0
        if (i_cmd.div_init) begin
            r_dvd <= 17'h10000;
            r_q   <= '0;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[15:0], 1'b0};
            if (rs >= {1'b0, i_cmd.n}) begin
                r_rem <= rs - {1'b0, i_cmd.n};
                r_q   <= {r_q[15:0], 1'b1};
            end else begin
                r_rem <= rs;
                r_q   <= {r_q[15:0], 1'b0};
            end
        end

        // t = floor(j*2^16/N), advanced by q0 plus a carry from the remainder
        if (i_cmd.seg_init) begin
            r_t <= '0;
            r_r <= '0;
        end else if (i_cmd.t_adv) begin
            if (rsum >= {1'b0, i_cmd.n}) begin
                r_r <= rsum - {1'b0, i_cmd.n};
                r_t <= r_t + r_q + 17'd1;
            end else begin
                r_r <= rsum;
                r_t <= r_t + r_q;
            end
        end

        if (i_cmd.mul) begin
            r_prod <= mul_a * mul_b;
        end

        if (i_cmd.cons) begin
            if (i_cmd.op == OpT2) begin
                r_t2 <= r_prod[31:16];
            end else if (i_cmd.op == OpT3) begin
                r_t3 <= r_prod[31:16];
            end else if (i_cmd.op == OpPa) begin
                r_pa <= r_prod[35:0];
            end else if (i_cmd.op == OpPb) begin
                r_wt[0] <= wa[19:0];
                r_wt[1] <= wb[19:0];
                r_wt[2] <= wc[19:0];
                r_wt[3] <= wd[19:0];
            end else if (i_cmd.op < OpAttr) begin
                if (kp[1:0] == 2'd0) begin
                    r_acc <= prod;
                end else if (kp[1:0] == 2'd3) begin
                    r_val[kp[3:2]] <= sat32(trunc16(wsum));
                end else begin
                    r_acc <= wsum;
                end
            end else if (!ka[0]) begin
                r_acc <= prod;
            end else begin
                r_val[attr] <= sat32(trunc16(wsum));
            end
        end

        if (i_cmd.emit) begin
            r_out.out_x      <= r_val[0];
            r_out.out_y      <= r_val[1];
            r_out.out_z      <= r_val[2];
            r_out.out_fov    <= r_val[3];
            r_out.out_aspect <= r_val[4];
            r_out.out_near   <= r_val[5];
            r_out.out_far    <= r_val[6];
            r_out.run_last   <= i_cmd.run_last;
            r_out.path_done  <= i_cmd.path_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

[hdl/catmull_rom_path_sampler_unit.sv]
// Catmull-Rom camera path sampler. Feed control points one word at a time
// (position plus fov, aspect, near and far clip, all signed Q16.16); mark the
// last point with path_end. From the third point on, each point yields N
// samples of the segment two points back; the end point also yields the final
// segment, and a one-point path yields nothing. Position follows the
// Catmull-Rom cubic with tension tau, the attributes are blended linearly,
// all products truncate toward zero and results saturate to 32 bits.
// One shared 20x33 multiplier does every product, 24 products per sample,
// each in a multiply state and then a consume state; emitting a sample
// waits while the sink holds the output register. A point that emits samples
// first runs a serial divide to find the step of t. The input is held until
// the point has emitted its N or 2N samples, or has shifted in if none. The
// output register lets the last sample wait for the sink while the next point
// is taken. Write samples_per_segment (index 0) and tension (index 1) only
// while the block is idle.
module catmull_rom_path_sampler_unit #(
    parameter int MAX_SAMPLES = crps_pkg::MaxSamples
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  crps_pkg::t_in_word            i_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output crps_pkg::t_out_word           o_out,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [crps_pkg::TauWidth-1:0] i_cfg_data
);
    import crps_pkg::*;

    logic [NWidth-1:0]   r_samples;
    logic [TauWidth-1:0] r_tension;
    t_cmd                cmd;
    t_stat               stat;

    // hold the configuration registers; write without wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= NReset;
            r_tension <= TauReset;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CfgSamples) begin
                r_samples <= i_cfg_data[NWidth-1:0];
            end else if (i_cfg_idx == CfgTension) begin
                r_tension <= i_cfg_data;
            end
        end
    end

    // sequence divide, multiply-accumulate steps and output words
    crps_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_path_end (i_in.path_end),
        .i_n        (r_samples),
        .i_stat     (stat),
        .o_ready    (o_ready),
        .o_cmd      (cmd)
    );

    // point window, shared multiplier, accumulators and output register
    crps_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .i_tau   (r_tension),
        .i_ready (i_ready),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

endmodule
